[rtl/msea_pkg.sv]
// Package of the mean squared error accumulator.
// Holds widths, limits and the command and status words between control and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package msea_pkg;

  // Field and state widths
  localparam int unsigned DataW  = 16;
  localparam int unsigned MagW   = 16;
  localparam int unsigned SqW    = 32;
  localparam int unsigned SumW   = 49;
  localparam int unsigned CountW = 17;
  localparam int unsigned MeanW  = 32;

  // Item limit per vector
  localparam logic [CountW-1:0] MaxItems = CountW'(65536);

  // Divider: the quotient fits in MeanW bits, so one step per quotient bit
  localparam int unsigned DivSteps = MeanW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivSteps - 1);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // take the input word
    logic div_load;  // load the divider from the finished sum
    logic div_step;  // run one divider step
    logic out_load;  // move the quotient into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_last;  // the current divider step is the final one
    logic out_free;  // the output register can take a word this cycle
  } sts_t;

endpackage

[rtl/msea_if.sv]
// Stream interfaces of the mean squared error accumulator.
// Input channel carries one element pair, output channel carries one mean.
// Depends on msea_pkg.
`timescale 1ns / 1ps

interface msea_in_if;
  import msea_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  predicted_value;
  logic signed [DataW-1:0]  target_value;
  logic                     last_element;

  modport source (output valid, output predicted_value, output target_value,
                  output last_element, input ready);
  modport sink   (input valid, input predicted_value, input target_value,
                  input last_element, output ready);
endinterface

interface msea_out_if;
  import msea_pkg::*;

  logic               valid;
  logic               ready;
  logic [MeanW-1:0]   mean_loss;
  logic [CountW-1:0]  element_count;
  logic               count_overflow;

  modport source (output valid, output mean_loss, output element_count,
                  output count_overflow, input ready);
  modport sink   (input valid, input mean_loss, input element_count,
                  input count_overflow, output ready);
endinterface

[rtl/mean_squared_error_accumulator.sv]
// Top level of the mean squared error accumulator.
// Joins controller and datapath to the input and output stream interfaces.
// Depends on msea_pkg, msea_if, msea_ctrl and msea_dp.
//
//   channel  dir  word contents
//   in_i     in   predicted_value, target_value, last_element
//   out_o    out  mean_loss, element_count, count_overflow
//
// Words without last_element are accepted back to back.
// After a last word, no word is accepted until the controller has finished the sum,
// run the 32 one-bit steps of the serial divider and loaded the output register.
// A mean waiting on out_o does not hold up accumulation of the next vector;
// only loading the following mean waits for out_o to be free.
// Reset clears sum, count, overflow flag, controller and output valid.
`timescale 1ns / 1ps

module mean_squared_error_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  msea_in_if.sink      in_i,
  msea_out_if.source   out_o
);
  import msea_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_element),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  msea_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .predicted_i (in_i.predicted_value),
    .target_i    (in_i.target_value),
    .last_i      (in_i.last_element),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .mean_o      (out_o.mean_loss),
    .count_o     (out_o.element_count),
    .overflow_o  (out_o.count_overflow)
  );

endmodule

[rtl/msea_ctrl.sv]
// Controller of the mean squared error accumulator.
// Sequences accumulate, divider load, divider steps and output load.
// Depends on msea_pkg.
`timescale 1ns / 1ps

module msea_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  input  msea_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output msea_pkg::cmd_t cmd_o
);
  import msea_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM = 4'b0001,
    ST_FIN   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_LOAD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Decode state into commands and next state
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/msea_dp.sv]
// Datapath of the mean squared error accumulator.
// Square stage, 49-bit accumulator, item counter, bit-serial divider, output register.
// Depends on msea_pkg.
`timescale 1ns / 1ps

module msea_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msea_pkg::cmd_t                 cmd_i,
  output msea_pkg::sts_t                 sts_o,
  input  logic signed [msea_pkg::DataW-1:0] predicted_i,
  input  logic signed [msea_pkg::DataW-1:0] target_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [msea_pkg::MeanW-1:0]     mean_o,
  output logic [msea_pkg::CountW-1:0]    count_o,
  output logic                           overflow_o
);
  import msea_pkg::*;

  logic signed [DataW:0] diff;
  logic [MagW-1:0]       mag;
  logic                  has_room;

  logic [SqW-1:0]    sq_q;
  logic              sq_acc_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] count_q, count_d, count_inc;
  logic              ovf_q, ovf_d, ovf_now;

  logic [CountW-1:0] div_cnt_q;
  logic              div_ovf_q;
  logic [CountW-1:0] rem_q, rem_d;
  logic [MeanW-1:0]  quo_q, quo_d;
  logic [DivCntW-1:0] step_q;
  logic [CountW:0]   trial;
  logic              trial_ge;

  logic              out_vld_q;
  logic [MeanW-1:0]  mean_q;
  logic [CountW-1:0] cnt_out_q;
  logic              ovf_out_q;

  // Absolute difference; it never exceeds 65535
  assign diff = $signed({predicted_i[DataW-1], predicted_i})
                - $signed({target_i[DataW-1], target_i});
  assign mag  = diff[DataW] ? MagW'(-diff) : MagW'(diff);

  // Register the square of the input word every cycle; sq_acc_q marks an accepted word
  always_ff @(posedge clk_i) begin
    sq_q <= mag * mag;
  end

  assign has_room = (count_q < MaxItems);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_acc_q <= 1'b0;
    end else begin
      sq_acc_q <= cmd_i.accept && has_room;
    end
  end

  // Add the registered square; clear when the divider takes the sum
  assign sum_d = sum_q + (sq_acc_q ? SumW'(sq_q) : SumW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (cmd_i.div_load) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // Count words and flag the ones dropped beyond the limit
  assign count_inc = has_room ? count_q + CountW'(1) : count_q;
  assign ovf_now   = ovf_q || !has_room;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.accept) begin
      if (last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_inc;
        ovf_d   = ovf_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Hold the vector's count and flag for the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && last_i) begin
      div_cnt_q <= count_inc;
      div_ovf_q <= ovf_now;
    end
  end

  // One restoring division step per cycle, quotient bit into the low end
  assign trial    = {rem_q, quo_q[MeanW-1]};
  assign trial_ge = (trial >= {1'b0, div_cnt_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.div_load) begin
      rem_d = sum_d[SumW-1:MeanW];
      quo_d = sum_d[MeanW-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = trial_ge ? CountW'(trial - {1'b0, div_cnt_q}) : trial[CountW-1:0];
      quo_d = {quo_q[MeanW-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Step counter of the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_load) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + DivCntW'(1);
    end
  end

  // Output register; an empty count gives a zero mean
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_q    <= (div_cnt_q == '0) ? '0 : quo_q;
      cnt_out_q <= div_cnt_q;
      ovf_out_q <= div_ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.div_last = (step_q == DivLastStep);
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign mean_o      = mean_q;
  assign count_o     = cnt_out_q;
  assign overflow_o  = ovf_out_q;

endmodule

[tb/mean_squared_error_accumulator_tb.sv]
// Testbench of the mean squared error accumulator: streams element pairs, predicts each mean.
// Checks every output word field by field against its own running-sum predictor.
// Depends on msea_pkg, msea_if and the mean_squared_error_accumulator top level.
`timescale 1ns / 1ps

module mean_squared_error_accumulator_tb;
  import msea_pkg::*;

  typedef struct packed {
    logic [MeanW-1:0]  mean_loss;
    logic [CountW-1:0] element_count;
    logic              count_overflow;
  } mean_word_t;

  localparam int unsigned SettleCycles = 40;
  localparam int unsigned DrainLimit   = 100000;

  logic clk_i;
  logic rst_ni;

  msea_in_if  in_if ();
  msea_out_if out_if ();

  mean_squared_error_accumulator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: running sum, count and overflow flag of the open vector
  logic [SumW-1:0]   sq_sum_acc   = '0;
  logic [CountW-1:0] elem_cnt_acc = '0;
  logic              ovf_acc      = 1'b0;

  mean_word_t expected_means[$];
  int unsigned error_count = 0;
  int unsigned words_sent  = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Fold one element pair into the running sum; return 1 when a mean is due
  function automatic bit mse_accumulate(input logic signed [DataW-1:0] pred,
                                        input logic signed [DataW-1:0] tgt,
                                        input logic last, output mean_word_t w);
    longint            diff;
    longint unsigned   sq;
    diff = longint'(pred) - longint'(tgt);
    if (diff < 0) diff = -diff;
    sq = longint'(diff) * diff;
    w  = '0;
    if (elem_cnt_acc < MaxItems) begin
      sq_sum_acc   = sq_sum_acc + SumW'(sq);
      elem_cnt_acc = elem_cnt_acc + 1'b1;
    end else begin
      ovf_acc = 1'b1;
    end
    if (!last) return 1'b0;
    w.mean_loss      = (elem_cnt_acc != 0) ? MeanW'(sq_sum_acc / elem_cnt_acc) : '0;
    w.element_count  = elem_cnt_acc;
    w.count_overflow = ovf_acc;
    sq_sum_acc   = '0;
    elem_cnt_acc = '0;
    ovf_acc      = 1'b0;
    return 1'b1;
  endfunction

  // Pick a Q4.12 value, weighted toward the extremes
  function automatic logic signed [DataW-1:0] pick_q412();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return DataW'($urandom_range(0, 15)) - 16'sd8;
      default: return DataW'($urandom);
    endcase
  endfunction

  // Send one word, optionally after an idle burst; leave valid high afterwards
  task automatic send_pair(input logic signed [DataW-1:0] pred,
                           input logic signed [DataW-1:0] tgt, input logic last);
    mean_word_t w;
    bit         due;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.predicted_value <= pred;
    in_if.target_value    <= tgt;
    in_if.last_element    <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    due = mse_accumulate(pred, tgt, last, w);
    if (due) expected_means.push_back(w);
    words_sent++;
  endtask

  // Hold the input idle until every pending mean has come out, then settle
  task automatic wait_drained();
    int unsigned n;
    n = 0;
    in_if.valid <= 1'b0;
    while (expected_means.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Extremes, single-word vectors and truncation of the mean
  task automatic test_directed();
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sh0001, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh0001, 1'b0);
    send_pair(16'sh1234, 16'sh1234, 1'b1);
    send_pair(16'sh0003, 16'sh0002, 1'b0);
    send_pair(16'shFFFE, 16'sh0000, 1'b1);
    send_pair(16'shFFFF, 16'sh0001, 1'b0);
    send_pair(16'sh5555, 16'shAAAA, 1'b0);
    send_pair(16'shAAAA, 16'sh5555, 1'b0);
    send_pair(16'sh7FFF, 16'sh0000, 1'b1);
  endtask

  // Random vectors, mostly short, a few long
  task automatic test_random_vectors(input int unsigned n_words);
    int unsigned stop_at;
    int unsigned len;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
      for (int unsigned i = 1; i <= len; i++) send_pair(pick_q412(), pick_q412(), i == len);
    end
  endtask

  // Pause the sender until every mean is out, then resume
  task automatic test_drain_pause();
    send_pair(pick_q412(), pick_q412(), 1'b0);
    send_pair(pick_q412(), pick_q412(), 1'b1);
    wait_drained();
    send_pair(16'sh7FFF, 16'sh8000, 1'b1);
  endtask

  // Output stall generator: random stall bursts while enabled
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted mean with the oldest prediction
  always @(posedge clk_i) begin
    mean_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_means.size() == 0) begin
        $error("unexpected mean word: mean_loss %0d, element_count %0d",
               out_if.mean_loss, out_if.element_count);
        error_count++;
      end else begin
        exp_w = expected_means.pop_front();
        if (out_if.mean_loss !== exp_w.mean_loss) begin
          $error("mean_loss: expected %0d, actual %0d", exp_w.mean_loss, out_if.mean_loss);
          error_count++;
        end
        if (out_if.element_count !== exp_w.element_count) begin
          $error("element_count: expected %0d, actual %0d",
                 exp_w.element_count, out_if.element_count);
          error_count++;
        end
        if (out_if.count_overflow !== exp_w.count_overflow) begin
          $error("count_overflow: expected %0d, actual %0d",
                 exp_w.count_overflow, out_if.count_overflow);
          error_count++;
        end
      end
    end
  end

  // Test sequence
  initial begin
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.predicted_value <= '0;
    in_if.target_value    <= '0;
    in_if.last_element    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_vectors(800);
    test_drain_pause();
    test_random_vectors(700);

    // Final stretch runs without gaps or stalls
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_random_vectors(350);

    wait_drained();
    if (expected_means.size() != 0) begin
      $error("%0d mean words never arrived", expected_means.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
